@@ rtl/biquad_magnitude_response_top_macros.svh @@
// assertion macros shared by the biquad magnitude response rtl
// no dependencies; taken in by `include where assertions are written
`ifndef BIQUAD_MAGNITUDE_RESPONSE_TOP_MACROS_SVH
`define BIQUAD_MAGNITUDE_RESPONSE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define BMR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define BMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bmr_pkg.sv @@
// shared types and constants of the biquad magnitude response block
// no dependencies; imported by bmr_coef, bmr_eval and the top level
package bmr_pkg;

    localparam int FREQ_W  = 16;
    localparam int COEF_W  = 48;
    localparam int LSQ_W   = 96;
    localparam int MAG_W   = 32;

    // filter type codes (code 7 falls back to lowpass)
    localparam logic [2:0] FT_LOWPASS    = 3'd0;
    localparam logic [2:0] FT_HIGHPASS   = 3'd1;
    localparam logic [2:0] FT_BANDPASS   = 3'd2;
    localparam logic [2:0] FT_NOTCH      = 3'd3;
    localparam logic [2:0] FT_PEAK       = 3'd4;
    localparam logic [2:0] FT_LOW_SHELF  = 3'd5;
    localparam logic [2:0] FT_HIGH_SHELF = 3'd6;

    // register indexes
    localparam logic [1:0] REG_FILTER_TYPE = 2'd0;
    localparam logic [1:0] REG_CENTER_FREQ = 2'd1;
    localparam logic [1:0] REG_QUALITY     = 2'd2;
    localparam logic [1:0] REG_GAIN        = 2'd3;

    // register reset values
    localparam logic [2:0]  RST_FILTER_TYPE = FT_LOWPASS;
    localparam logic [15:0] RST_CENTER_FREQ = 16'd4096;
    localparam logic [15:0] RST_QUALITY     = 16'd2896;
    localparam logic [23:0] RST_GAIN        = 24'd65536;

    // 1.0 in Q24 and the coefficient clamp value
    localparam logic [COEF_W-1:0] COEF_ONE = 48'h000001000000;
    localparam logic [COEF_W-1:0] COEF_MAX = 48'hFFFFFFFFFFFF;

    typedef struct packed {
        logic [2:0]  filter_type;
        logic [15:0] center_freq;
        logic [15:0] quality;
        logic [23:0] gain;
    } bmr_cfg_t;

    // one quadratic form: quad * w^2, lin^2 * w^2, cst
    typedef struct packed {
        logic [COEF_W-1:0] quad;
        logic [LSQ_W-1:0]  lin_sq;
        logic [COEF_W-1:0] cst;
    } bmr_coef_t;

endpackage

@@ rtl/bmr_coef.sv @@
// prototype coefficient derivation: shared serial square root, divider and squarer
// depends on bmr_pkg
module bmr_coef import bmr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  bmr_cfg_t  cfg,
    input  logic      cfg_write,
    output logic      coef_ready,
    output bmr_coef_t den_coef,
    output bmr_coef_t num_coef
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQRT = 6'b000010,
        S_PREP = 6'b000100,
        S_DIV  = 6'b001000,
        S_SEL  = 6'b010000,
        S_SQR  = 6'b100000
    } state_t;

    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQR_LAST  = 6'd47;

    localparam logic [2:0] OP_SQRT_GAIN = 3'd0;
    localparam logic [2:0] OP_SQRT_A    = 3'd1;
    localparam logic [2:0] DV_W0Q       = 3'd0;
    localparam logic [2:0] DV_PK_C1     = 3'd1;
    localparam logic [2:0] DV_PK_C4     = 3'd2;
    localparam logic [2:0] DV_SH_C1     = 3'd3;
    localparam logic [2:0] DV_SH_C4     = 3'd4;
    localparam logic [2:0] SQ_DEN       = 3'd0;

    localparam logic [63:0] SQRT_BIT0 = 64'h4000000000000000;

    state_t      state_reg;
    logic        pend_reg;
    logic [5:0]  cnt_reg;
    logic [2:0]  op_reg;

    logic [63:0] sx_reg, sr_reg, sb_reg;
    logic [27:0] a_reg;
    logic [25:0] s_reg;
    logic [29:0] as_reg;
    logic [43:0] aq_reg;
    logic [31:0] w0sq_reg;
    logic [63:0] dn_reg, dd_reg, dq_reg;
    logic [63:0] drem_reg;
    logic [COEF_W-1:0] w0q_reg, pkc1_reg, pkc4_reg, shc1_reg, shc4_reg;
    logic [COEF_W-1:0] lin1_reg, lin4_reg;
    logic [LSQ_W-1:0]  ms_reg, macc_reg;
    logic [COEF_W-1:0] mb_reg;
    bmr_coef_t   den_reg, num_reg;

    // square root step
    logic [63:0] sq_t;
    logic        sq_ge;
    logic [63:0] sx_next, sr_next, sb_next;

    assign sq_t    = sr_reg + sb_reg;
    assign sq_ge   = sx_reg >= sq_t;
    assign sx_next = sq_ge ? sx_reg - sq_t : sx_reg;
    assign sr_next = sq_ge ? (sr_reg >> 1) + sb_reg : sr_reg >> 1;
    assign sb_next = sb_reg >> 2;

    // products, each feeding a register
    logic [43:0] w0a;
    logic [41:0] sw0;
    logic [45:0] asw0;
    logic [53:0] a_s;
    logic [43:0] a_q;
    logic [31:0] w0_sq;
    logic [59:0] a_w0sq;

    assign w0a    = cfg.center_freq * a_reg;
    assign sw0    = s_reg * cfg.center_freq;
    assign asw0   = as_reg * cfg.center_freq;
    assign a_s    = a_reg * s_reg;
    assign a_q    = a_reg * cfg.quality;
    assign w0_sq  = cfg.center_freq * cfg.center_freq;
    assign a_w0sq = a_reg * w0sq_reg;

    // divider operands of the next division
    logic [2:0]  op_div;
    logic [63:0] div_n, div_d;

    assign op_div = (state_reg == S_PREP) ? DV_W0Q : op_reg + 3'd1;

    always_comb begin
        unique case (op_div)
            DV_W0Q: begin
                div_n = {24'd0, cfg.center_freq, 24'd0};
                div_d = {48'd0, cfg.quality};
            end
            DV_PK_C1: begin
                div_n = {cfg.center_freq, 48'd0};
                div_d = {20'd0, aq_reg};
            end
            DV_PK_C4: begin
                div_n = {20'd0, w0a};
                div_d = {48'd0, cfg.quality};
            end
            DV_SH_C1: begin
                div_n = {22'd0, sw0};
                div_d = {48'd0, cfg.quality};
            end
            DV_SH_C4: begin
                div_n = {18'd0, asw0};
                div_d = {48'd0, cfg.quality};
            end
            default: begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    // restoring division step and clamped result
    logic [64:0] dv_sh;
    logic        dv_ge;
    logic [63:0] dq_fin;
    logic [COEF_W-1:0] div_res;

    assign dv_sh   = {drem_reg, dn_reg[63]};
    assign dv_ge   = dv_sh >= {1'b0, dd_reg};
    assign dq_fin  = {dq_reg[62:0], dv_ge};
    assign div_res = ((dd_reg == '0) || (dq_fin[63:48] != '0)) ? COEF_MAX : dq_fin[47:0];

    // shift-add squarer step
    logic [LSQ_W-1:0] macc_next;
    assign macc_next = macc_reg + (mb_reg[0] ? ms_reg : '0);

    // coefficient selection by filter type
    logic [COEF_W-1:0] c0, c1, c2, c3, c4, c5;
    logic [COEF_W-1:0] a48, g8, shc5;

    assign a48  = {20'd0, a_reg};
    assign g8   = {16'd0, cfg.gain, 8'd0};
    assign shc5 = {12'd0, a_w0sq[59:24]};

    always_comb begin
        c0 = COEF_ONE;
        c1 = w0q_reg;
        c2 = {16'd0, w0sq_reg};
        c3 = '0;
        c4 = '0;
        c5 = {16'd0, w0sq_reg};
        unique case (cfg.filter_type)
            FT_HIGHPASS: begin
                c3 = COEF_ONE;
                c5 = '0;
            end
            FT_BANDPASS: begin
                c4 = w0q_reg;
                c5 = '0;
            end
            FT_NOTCH: c3 = COEF_ONE;
            FT_PEAK: begin
                c1 = pkc1_reg;
                c3 = COEF_ONE;
                c4 = pkc4_reg;
            end
            FT_LOW_SHELF: begin
                c0 = a48;
                c1 = shc1_reg;
                c3 = a48;
                c4 = shc4_reg;
                c5 = shc5;
            end
            FT_HIGH_SHELF: begin
                c1 = shc1_reg;
                c3 = g8;
                c4 = shc4_reg;
                c5 = shc5;
            end
            default: ;
        endcase
    end

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b1;
            cnt_reg   <= '0;
            op_reg    <= '0;
        end else begin
            if (cfg_write) begin
                pend_reg <= 1'b1;
            end else if (state_reg == S_IDLE) begin
                pend_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (pend_reg) begin
                        state_reg <= S_SQRT;
                        cnt_reg   <= '0;
                        op_reg    <= OP_SQRT_GAIN;
                    end
                end
                S_SQRT: begin
                    if (cnt_reg == SQRT_LAST) begin
                        cnt_reg <= '0;
                        if (op_reg == OP_SQRT_GAIN) begin
                            op_reg <= OP_SQRT_A;
                        end else begin
                            op_reg    <= DV_W0Q;
                            state_reg <= S_PREP;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_PREP: begin
                    state_reg <= S_DIV;
                    cnt_reg   <= '0;
                    op_reg    <= DV_W0Q;
                end
                S_DIV: begin
                    if (cnt_reg == DIV_LAST) begin
                        cnt_reg <= '0;
                        if (op_reg == DV_SH_C4) begin
                            op_reg    <= SQ_DEN;
                            state_reg <= S_SEL;
                        end else begin
                            op_reg <= op_reg + 3'd1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_SEL: begin
                    state_reg <= S_SQR;
                    cnt_reg   <= '0;
                    op_reg    <= SQ_DEN;
                end
                S_SQR: begin
                    if (cnt_reg == SQR_LAST) begin
                        cnt_reg <= '0;
                        if (op_reg == SQ_DEN) begin
                            op_reg <= op_reg + 3'd1;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                sx_reg <= {8'd0, cfg.gain, 32'd0};
                sr_reg <= '0;
                sb_reg <= SQRT_BIT0;
            end
            S_SQRT: begin
                if (cnt_reg == SQRT_LAST && op_reg == OP_SQRT_GAIN) begin
                    a_reg  <= sr_next[27:0];
                    sx_reg <= {12'd0, sr_next[27:0], 24'd0};
                    sr_reg <= '0;
                    sb_reg <= SQRT_BIT0;
                end else if (cnt_reg == SQRT_LAST) begin
                    s_reg <= sr_next[25:0];
                end else begin
                    sx_reg <= sx_next;
                    sr_reg <= sr_next;
                    sb_reg <= sb_next;
                end
            end
            S_PREP: begin
                as_reg   <= a_s[53:24];
                aq_reg   <= a_q;
                w0sq_reg <= w0_sq;
                dn_reg   <= div_n;
                dd_reg   <= div_d;
                drem_reg <= '0;
                dq_reg   <= '0;
            end
            S_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    unique case (op_reg)
                        DV_W0Q:   w0q_reg  <= div_res;
                        DV_PK_C1: pkc1_reg <= div_res;
                        DV_PK_C4: pkc4_reg <= div_res;
                        DV_SH_C1: shc1_reg <= div_res;
                        default:  shc4_reg <= div_res;
                    endcase
                    dn_reg   <= div_n;
                    dd_reg   <= div_d;
                    drem_reg <= '0;
                    dq_reg   <= '0;
                end else begin
                    drem_reg <= dv_ge ? 64'(dv_sh - {1'b0, dd_reg}) : dv_sh[63:0];
                    dq_reg   <= dq_fin;
                    dn_reg   <= {dn_reg[62:0], 1'b0};
                end
            end
            S_SEL: begin
                den_reg.quad <= c0;
                den_reg.cst  <= c2;
                num_reg.quad <= c3;
                num_reg.cst  <= c5;
                lin1_reg     <= c1;
                lin4_reg     <= c4;
                ms_reg       <= {48'd0, c1};
                mb_reg       <= c1;
                macc_reg     <= '0;
            end
            S_SQR: begin
                if (cnt_reg == SQR_LAST && op_reg == SQ_DEN) begin
                    den_reg.lin_sq <= macc_next;
                    ms_reg         <= {48'd0, lin4_reg};
                    mb_reg         <= lin4_reg;
                    macc_reg       <= '0;
                end else if (cnt_reg == SQR_LAST) begin
                    num_reg.lin_sq <= macc_next;
                end else begin
                    ms_reg   <= {ms_reg[LSQ_W-2:0], 1'b0};
                    mb_reg   <= {1'b0, mb_reg[COEF_W-1:1]};
                    macc_reg <= macc_next;
                end
            end
            default: ;
        endcase
    end

    assign coef_ready = (state_reg == S_IDLE) && !pend_reg;
    assign den_coef   = den_reg;
    assign num_coef   = num_reg;

endmodule

@@ rtl/bmr_eval.sv @@
// per-item evaluation pipeline: two quadratic forms, then a 32-stage restoring divider
// depends on bmr_pkg and biquad_magnitude_response_top_macros.svh
`include "biquad_magnitude_response_top_macros.svh"
module bmr_eval import bmr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FREQ_W-1:0] in_freq,
    input  bmr_coef_t         den_coef,
    input  bmr_coef_t         num_coef,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MAG_W-1:0]  out_mag,
    output logic              out_sat
);

    localparam int DIG_W     = 16;
    localparam int SQ_DIGITS = 5;
    localparam int QUO_W     = 32;
    localparam int SUM_W     = 161;
    localparam int REM_W     = 193;
    localparam int DIFF_W    = 80;

    // stage map
    localparam int ST_W2   = 0;
    localparam int ST_MLO  = 1;
    localparam int ST_MHI  = 2;
    localparam int ST_DIFF = 3;
    localparam int ST_SQ0  = 4;
    localparam int ST_SUM  = ST_SQ0 + SQ_DIGITS;
    localparam int ST_CHK  = ST_SUM + 1;
    localparam int ST_DIV0 = ST_CHK + 1;
    localparam int ST_OUT  = ST_DIV0 + QUO_W;
    localparam int N_ST    = ST_OUT + 1;

    logic [N_ST-1:0] vld_reg;
    logic [N_ST:0]   adv;

    // a stage advances when it is empty or its successor advances
    assign adv[N_ST] = out_ready;
    for (genvar i = 0; i < N_ST; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N_ST; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign in_ready = adv[0];

    // w squared and its upper digit
    logic [31:0] w2_reg;
    logic [15:0] w2hi_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_W2]) begin
            w2_reg <= in_freq * in_freq;
        end
        if (adv[ST_MLO]) begin
            w2hi_reg <= w2_reg[31:16];
        end
    end

    function automatic logic [159:0] sq_part(input logic [DIFF_W-1:0] d, input int j);
        logic [95:0] p;
        p = d * d[j*DIG_W +: DIG_W];
        return {64'd0, p} << (j*DIG_W);
    endfunction

    logic [SUM_W-1:0] sum_side [2];

    // side 0 is the denominator, side 1 the numerator
    for (genvar s = 0; s < 2; s++) begin : g_side
        bmr_coef_t         cf;
        logic [63:0]       a_hi;
        logic [111:0]      t_hi;
        logic [71:0]       kx;
        logic [63:0]       alo_reg;
        logic [111:0]      tlo_reg;
        logic [DIFF_W-1:0] a_reg;
        logic [127:0]      t_reg;
        logic [DIFF_W-1:0] d_reg   [SQ_DIGITS];
        logic [127:0]      tq_reg  [SQ_DIGITS+1];
        logic [159:0]      acc_reg [SQ_DIGITS];
        logic [SUM_W-1:0]  sum_reg;

        assign cf   = (s == 0) ? den_coef : num_coef;
        assign a_hi = cf.quad * w2hi_reg;
        assign t_hi = cf.lin_sq * w2hi_reg;
        assign kx   = {cf.cst, 24'd0};

        always_ff @(posedge aclk) begin
            // low partial products
            if (adv[ST_MLO]) begin
                alo_reg <= cf.quad * w2_reg[15:0];
                tlo_reg <= cf.lin_sq * w2_reg[15:0];
            end
            // high partial products merged
            if (adv[ST_MHI]) begin
                a_reg <= {16'd0, alo_reg} + {a_hi, 16'd0};
                t_reg <= {16'd0, tlo_reg} + {t_hi, 16'd0};
            end
            // distance between constant and quadratic term
            if (adv[ST_DIFF]) begin
                d_reg[0]  <= ({8'd0, kx} >= a_reg) ? {8'd0, kx} - a_reg : a_reg - {8'd0, kx};
                tq_reg[0] <= t_reg;
            end
            // square of the distance, one digit a stage
            for (int j = 0; j < SQ_DIGITS; j++) begin
                if (adv[ST_SQ0+j]) begin
                    acc_reg[j]  <= ((j == 0) ? 160'd0 : acc_reg[(j == 0) ? 0 : j-1])
                                   + sq_part(d_reg[j], j);
                    tq_reg[j+1] <= tq_reg[j];
                    if (j < SQ_DIGITS - 1) begin
                        d_reg[(j < SQ_DIGITS - 1) ? j+1 : 0] <= d_reg[j];
                    end
                end
            end
            if (adv[ST_SUM]) begin
                sum_reg <= {1'b0, acc_reg[SQ_DIGITS-1]} + {9'd0, tq_reg[SQ_DIGITS], 24'd0};
            end
        end

        assign sum_side[s] = sum_reg;
    end

    // divider pipeline, element 0 is the range check stage
    logic [REM_W-1:0] st_rem_reg [QUO_W+1];
    logic [SUM_W-1:0] st_den_reg [QUO_W+1];
    logic [QUO_W-1:0] st_q_reg   [QUO_W+1];
    logic             st_sat_reg [QUO_W+1];
    logic [REM_W-1:0] dsh        [QUO_W];
    logic [QUO_W-1:0] ge;
    logic [MAG_W-1:0] out_mag_reg;
    logic             out_sat_reg;

    always_comb begin
        for (int i = 0; i < QUO_W; i++) begin
            dsh[i] = {32'd0, st_den_reg[i]} << (QUO_W - 1 - i);
            ge[i]  = st_rem_reg[i] >= dsh[i];
        end
    end

    always_ff @(posedge aclk) begin
        // zero denominator or quotient at or above 2^16 saturates
        if (adv[ST_CHK]) begin
            st_rem_reg[0] <= {16'd0, sum_side[1], 16'd0};
            st_den_reg[0] <= sum_side[0];
            st_q_reg[0]   <= '0;
            st_sat_reg[0] <= (sum_side[0] == '0) ||
                             ({16'd0, sum_side[1]} >= {sum_side[0], 16'd0});
        end
        // one quotient bit a stage, msb first
        for (int i = 0; i < QUO_W; i++) begin
            if (adv[ST_DIV0+i]) begin
                st_rem_reg[i+1] <= ge[i] ? st_rem_reg[i] - dsh[i] : st_rem_reg[i];
                st_den_reg[i+1] <= st_den_reg[i];
                st_q_reg[i+1]   <= st_q_reg[i] | ({31'd0, ge[i]} << (QUO_W - 1 - i));
                st_sat_reg[i+1] <= st_sat_reg[i];
            end
        end
        // output register
        if (adv[ST_OUT]) begin
            out_mag_reg <= st_sat_reg[QUO_W] ? '1 : st_q_reg[QUO_W];
            out_sat_reg <= st_sat_reg[QUO_W];
        end
    end

    assign out_valid = vld_reg[ST_OUT];
    assign out_mag   = out_mag_reg;
    assign out_sat   = out_sat_reg;

    `BMR_ASSERT_IMPL(a_sat_full_scale, aclk, aresetn, out_valid && out_sat, (out_mag == '1), "saturated item without full-scale magnitude")
    `BMR_ASSERT_NEXT(a_stall_keeps_item, aclk, aresetn, vld_reg[ST_OUT-1] && !adv[ST_OUT-1], vld_reg[ST_OUT-1], "stalled divider stage lost its item")
    `BMR_ASSERT_IMPL(a_quotient_bound, aclk, aresetn, vld_reg[ST_CHK] && !st_sat_reg[0], (st_rem_reg[0] < {st_den_reg[0], 32'd0}), "unsaturated item would overflow the quotient")

endmodule

@@ rtl/biquad_magnitude_response_top.sv @@
// top level of the biquad magnitude response block: apb registers and stream channels
// depends on bmr_pkg, bmr_coef and bmr_eval
//
// Usage:
// - the apb port holds four registers at byte addresses 0, 4, 8, 12: filter type,
//   center frequency (Q4.12), quality (Q4.12) and gain (Q8.16); writes take effect
//   at the access cycle, reads return the stored value, pready is always high
// - after reset and after each register write the six prototype coefficients are
//   derived by a serial square root, divider and squarer; during that time s_tready
//   stays low, register writes are taken as ever
// - each accepted item on s_ (frequency, Q4.12) gives one item on m_ (squared
//   magnitude Q16.16 in m_tdata, saturation flag in m_tuser)
// - one item is taken every cycle while the pipeline does not stall and the coefficients
//   are ready; the 32-stage restoring divider sets the depth
// - every stage holds its item while the next one is full and held, so a stalled receiver
//   lets the empty stages fill before s_tready falls; nothing is lost or repeated
// - reset is synchronous, active low, and empties the pipeline
module biquad_magnitude_response_top import bmr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] freq
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] magnitude_squared
    output logic [0:0]  m_tuser,   // [0] saturated
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bmr_cfg_t  cfg_reg;
    logic      cfg_wr;
    logic      coef_ready;
    bmr_coef_t den_coef, num_coef;
    logic      eval_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_type <= RST_FILTER_TYPE;
            cfg_reg.center_freq <= RST_CENTER_FREQ;
            cfg_reg.quality     <= RST_QUALITY;
            cfg_reg.gain        <= RST_GAIN;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FILTER_TYPE: cfg_reg.filter_type <= pwdata[2:0];
                REG_CENTER_FREQ: cfg_reg.center_freq <= pwdata[15:0];
                REG_QUALITY:     cfg_reg.quality     <= pwdata[15:0];
                REG_GAIN:        cfg_reg.gain        <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            REG_FILTER_TYPE: prdata = {29'd0, cfg_reg.filter_type};
            REG_CENTER_FREQ: prdata = {16'd0, cfg_reg.center_freq};
            REG_QUALITY:     prdata = {16'd0, cfg_reg.quality};
            REG_GAIN:        prdata = {8'd0, cfg_reg.gain};
            default:         prdata = '0;
        endcase
    end

    // coefficient derivation
    bmr_coef u_coef (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cfg_write  (cfg_wr),
        .coef_ready (coef_ready),
        .den_coef   (den_coef),
        .num_coef   (num_coef)
    );

    // per-item pipeline
    bmr_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && coef_ready),
        .in_ready  (eval_ready),
        .in_freq   (s_tdata),
        .den_coef  (den_coef),
        .num_coef  (num_coef),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mag   (m_tdata),
        .out_sat   (m_tuser[0])
    );

    assign s_tready = eval_ready && coef_ready;

endmodule

@@ dv/biquad_magnitude_response_top_tb.sv @@
// testbench for biquad_magnitude_response_top: random frequency sweeps under many filter setups
// depends on bmr_pkg and the rtl of biquad_magnitude_response_top; expected results come
// from an exact squared-magnitude predictor held in a small scoreboard class
`timescale 1ns / 100ps

module biquad_magnitude_response_top_tb import bmr_pkg::*;;

    typedef bit [63:0]  u64_t;
    typedef bit [255:0] wide_t;

    localparam u64_t CLAMP48 = (64'd1 << 48) - 1;

    typedef struct {
        bit [31:0] mag_sq;
        bit        sat;
    } response_t;

    // scoreboard: register copy, derived coefficients and the queue of expected responses
    class response_scoreboard;
        bit [2:0]  ftype;
        bit [15:0] w0;
        bit [15:0] qual;
        bit [23:0] gain;
        u64_t      coef [6];
        response_t expected_q [$];
        int        err_count;

        function new();
            ftype = RST_FILTER_TYPE;
            w0    = RST_CENTER_FREQ;
            qual  = RST_QUALITY;
            gain  = RST_GAIN;
            err_count = 0;
            derive_coefs();
        endfunction

        function u64_t int_sqrt(u64_t x);
            u64_t r;
            u64_t b;
            r = 0;
            b = 64'h4000000000000000;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function u64_t div_sat48(u64_t n, u64_t d);
            u64_t quo;
            if (d == 0) return CLAMP48;
            quo = n / d;
            return (quo > CLAMP48) ? CLAMP48 : quo;
        endfunction

        function void derive_coefs();
            u64_t a_lin, s_rt, a_s, w0sq, w0q, w, q, g;
            w = w0;
            q = qual;
            g = gain;
            a_lin = int_sqrt(g << 32);
            s_rt  = int_sqrt(a_lin << 24);
            a_s   = (a_lin * s_rt) >> 24;
            w0sq  = w * w;
            w0q   = div_sat48(w << 24, q);
            coef[0] = COEF_ONE; coef[1] = w0q; coef[2] = w0sq;
            coef[3] = 0;        coef[4] = 0;   coef[5] = w0sq;
            case (ftype)
                FT_HIGHPASS: begin
                    coef[3] = COEF_ONE;
                    coef[5] = 0;
                end
                FT_BANDPASS: begin
                    coef[4] = w0q;
                    coef[5] = 0;
                end
                FT_NOTCH: coef[3] = COEF_ONE;
                FT_PEAK: begin
                    coef[1] = div_sat48(w << 48, a_lin * q);
                    coef[3] = COEF_ONE;
                    coef[4] = div_sat48(w * a_lin, q);
                end
                FT_LOW_SHELF, FT_HIGH_SHELF: begin
                    coef[0] = (ftype == FT_LOW_SHELF) ? a_lin : u64_t'(COEF_ONE);
                    coef[1] = div_sat48(s_rt * w, q);
                    coef[3] = (ftype == FT_LOW_SHELF) ? a_lin : (g << 8);
                    coef[4] = div_sat48(a_s * w, q);
                    coef[5] = (a_lin * w0sq) >> 24;
                end
                default: ;
            endcase
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] val);
            case (idx)
                REG_FILTER_TYPE: ftype = val[2:0];
                REG_CENTER_FREQ: w0    = val[15:0];
                REG_QUALITY:     qual  = val[15:0];
                REG_GAIN:        gain  = val[23:0];
            endcase
            derive_coefs();
        endfunction

        // lin^2 w^2 + (cst - quad w^2)^2, Q.96
        function wide_t quad_form(u64_t quad, u64_t lin, u64_t cst, u64_t w2);
            wide_t qq, ll, cc, ww, prod, diff;
            qq = quad; ll = lin; cc = cst; ww = w2;
            prod = qq * ww;
            cc = cc << 24;
            diff = (cc >= prod) ? cc - prod : prod - cc;
            return diff * diff + ((ll * ll * ww) << 24);
        endfunction

        function void note_freq(bit [15:0] freq);
            u64_t      w2;
            wide_t     den, num, quo;
            response_t r;
            w2 = u64_t'(freq) * u64_t'(freq);
            den = quad_form(coef[0], coef[1], coef[2], w2);
            num = quad_form(coef[3], coef[4], coef[5], w2);
            if (den == 0 || num >= (den << 16)) begin
                r.mag_sq = 32'hFFFFFFFF;
                r.sat = 1'b1;
            end else begin
                quo = (num << 16) / den;
                r.mag_sq = quo[31:0];
                r.sat = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            err_count++;
        endtask

        task check_response(bit [31:0] mag_sq, bit sat);
            response_t r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected item %08h sat %0d", mag_sq, sat));
            end else begin
                r = expected_q.pop_front();
                if (r.mag_sq != mag_sq)
                    report($sformatf("magnitude %08h, expected %08h", mag_sq, r.mag_sq));
                if (r.sat != sat)
                    report($sformatf("saturated %0d, expected %0d", sat, r.sat));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] freq
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] magnitude_squared
    logic [0:0]  m_tuser;    // [0] saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    response_scoreboard resp_sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_start;
    int hold_cnt;

    biquad_magnitude_response_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check accepted items, random stalls and a long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            resp_sb.check_response(m_tdata, m_tuser[0]);
        if (hold_start) begin
            hold_start = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // setup and access phase, then an idle gap with psel low before the next transfer
    task apb_write(bit [1:0] idx, bit [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        resp_sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task send_freq(bit [15:0] freq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= freq;
        do @(posedge aclk); while (!s_tready);
        resp_sb.note_freq(freq);
    endtask

    // wait until every expected item has come back, then let the pipe drain
    task drain();
        s_tvalid <= 1'b0;
        while (resp_sb.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task configure(bit [31:0] ft, bit [31:0] cf, bit [31:0] qv, bit [31:0] gv);
        drain();
        apb_write(REG_FILTER_TYPE, ft);
        apb_write(REG_CENTER_FREQ, cf);
        apb_write(REG_QUALITY, qv);
        apb_write(REG_GAIN, gv);
    endtask

    // half the frequencies near w0 so the response stays in range, a quarter anywhere, a quarter below 32
    function bit [15:0] pick_freq();
        int w;
        case ($urandom_range(3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 31));
            default: begin
                w = int'(resp_sb.w0) + $urandom_range(0, 2 * int'(resp_sb.w0)) - int'(resp_sb.w0);
                if (w < 0) w = 0;
                if (w > 65535) w = 65535;
                return 16'(w);
            end
        endcase
    endfunction

    // main sequence
    initial begin
        bit [15:0] edge_freqs [] = '{16'h0000, 16'hFFFF, 16'h1000, 16'h0001, 16'h8000,
                                     16'hAAAA, 16'h5555, 16'h0B50, 16'h2000, 16'h0800,
                                     16'h00FF, 16'hFF00, 16'h7FFF, 16'h0010};
        bit [31:0] cf, qv, gv;
        resp_sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start = 1'b0;
        hold_cnt = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes under the reset setup
        foreach (edge_freqs[i]) send_freq(edge_freqs[i]);

        // directed setups: masked type code, zero quality, zero gain peak, extremes
        configure(32'hFFFFFFFF, 32'h0001_1000, 32'h0000_0B50, 32'h0001_0000);
        send_freq(16'h1000);
        send_freq(16'h0000);
        configure(FT_LOWPASS, 16'h1000, 0, 24'h010000);
        send_freq(16'h0000);
        send_freq(16'h1000);
        configure(FT_PEAK, 16'h1000, 16'h1000, 0);
        send_freq(16'h0800);
        send_freq(16'hFFFF);
        configure(FT_PEAK, 16'hFFFF, 16'h0001, 24'hFFFFFF);
        send_freq(16'hFFFF);
        configure(FT_LOW_SHELF, 16'h0001, 16'hFFFF, 24'h000001);
        send_freq(16'h0001);
        configure(FT_HIGH_SHELF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_freq(16'h8000);

        // random phases, one setup each, idling rotates through four modes
        for (int ph = 0; ph < 16; ph++) begin
            cf = $urandom_range(64, 16384);
            qv = $urandom_range(512, 16384);
            gv = $urandom_range(1 << 12, 1 << 20);
            if (ph % 5 == 4) begin
                cf = $urandom_range(1, 65535);
                qv = $urandom_range(1, 65535);
                gv = $urandom_range(1, 24'hFFFFFF);
            end
            configure(ph % 8, cf, qv, gv);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < 82; n++) begin
                if (n == 10 && ph % 4 == 0) hold_start = 1'b1;
                send_freq(pick_freq());
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (resp_sb.err_count == 0)
            $display("biquad_magnitude_response_top_tb: done, clean");
        else
            $display("biquad_magnitude_response_top_tb: done, errors");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("biquad_magnitude_response_top_tb: done, errors");
        $finish;
    end

endmodule
